// ----- rtl/priority_round_robin_task_scheduler_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority round-robin task scheduler.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PRRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prrs assertion failed");
`define PRRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prrs assertion failed");
`else
`define PRRS_ASSERT_IMP(label, ante, cons)
`define PRRS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/prrs_pkg.sv -----
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared constants, slot state codes and interface structs of the scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int PRI_W      = 8;
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 3;

    localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WAKE   = 3'd4;

    typedef enum logic [2:0] {
        ST_FREE,
        ST_READY,
        ST_RUNNING,
        ST_BLOCKED,
        ST_DEAD
    } slot_st_t;

    typedef struct packed {
        logic             st_we;
        slot_st_t         st;
        logic             pri_we;
        logic [PRI_W-1:0] pri;
    } tbl_wr_t;

    typedef struct packed {
        logic is_free;
        logic is_ready;
        logic is_blocked;
        logic pri_gt;
        logic pri_eq;
    } cmp_res_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(SLOT_COUNT - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/priority_round_robin_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top
// Event-driven task scheduler over a table of slots, walked by a small sequencer.
// ----------------------------------------------------------------------------
// An item is one event: schedule, create, block current, exit current or wake.
// It is accepted at a rising edge with start high and busy low. Busy is high
// while the item is worked on and is low again in the cycle in which done is
// high. Each item gives exactly one result, shown on status, slot and
// running_valid for the single cycle in which done is high.
// The receiver cannot stall, so the result must be taken in that cycle.
// All table accesses go through one indexed port and one compare unit.
// Schedule walks the table once for the best ready priority, then round-robin
// until the pick, then demotes and commits. Create walks until the first free
// slot. Block, exit and wake each act on one table entry, and unused kinds on
// none. The done strobe is high in the cycle after the last step, or directly
// after the accepting edge for an unused kind, and the next item may start in
// the cycle done is high. After reset slot 0 is the ready idle task, all other
// slots are free and no task is running.
// ----------------------------------------------------------------------------
`include "priority_round_robin_task_scheduler_top_macros.svh"

module priority_round_robin_task_scheduler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [prrs_pkg::KIND_W-1:0]       kind,
    input  logic [prrs_pkg::PRI_W-1:0]        priority_req,
    input  logic [2:0]                        wake_slot,
    output logic                              done,
    output logic                              status,
    output logic [prrs_pkg::SLOT_W-1:0]       slot,
    output logic                              running_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEST,
        S_PICK,
        S_DEMOTE,
        S_COMMIT,
        S_FREE,
        S_KILL,
        S_WAKE
    } seq_st_t;

    localparam logic [prrs_pkg::IDX_W-1:0] LAST_IDX = prrs_pkg::IDX_W'(prrs_pkg::SLOT_COUNT - 1);

    seq_st_t                         fsm_reg, fsm_next;
    logic [prrs_pkg::KIND_W-1:0]     op_reg, op_next;
    logic [prrs_pkg::PRI_W-1:0]      req_pri_reg, req_pri_next;
    logic [prrs_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [prrs_pkg::IDX_W-1:0]      cnt_reg, cnt_next;
    logic [prrs_pkg::PRI_W-1:0]      best_reg, best_next;
    logic                            others_reg, others_next;
    logic [prrs_pkg::IDX_W-1:0]      pick_reg, pick_next;
    logic                            wake_ok_reg, wake_ok_next;
    logic [prrs_pkg::IDX_W-1:0]      last_pick_reg, last_pick_next;
    logic [prrs_pkg::IDX_W-1:0]      cur_slot_reg, cur_slot_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic                            run_flag_reg, run_flag_next;
    logic                            done_reg, done_next;
    logic                            status_reg, status_next;
    logic [prrs_pkg::SLOT_W-1:0]     slot_reg, slot_next;

    prrs_pkg::tbl_wr_t               tbl_wr;
    prrs_pkg::slot_st_t              rd_state;
    logic [prrs_pkg::PRI_W-1:0]      rd_pri;
    prrs_pkg::cmp_res_t              cmp;

    prrs_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (idx_reg),
        .wr       (tbl_wr),
        .rd_state (rd_state),
        .rd_pri   (rd_pri)
    );

    prrs_cmp u_cmp (
        .entry_state (rd_state),
        .entry_pri   (rd_pri),
        .top_pri     (best_reg),
        .res         (cmp)
    );

    always_comb
    begin
        fsm_next       = fsm_reg;
        op_next        = op_reg;
        req_pri_next   = req_pri_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        others_next    = others_reg;
        pick_next      = pick_reg;
        wake_ok_next   = wake_ok_reg;
        last_pick_next = last_pick_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        run_flag_next  = run_flag_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        tbl_wr         = '{st_we: 1'b0, st: prrs_pkg::ST_FREE, pri_we: 1'b0, pri: '0};

        case (fsm_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = kind;
                    req_pri_next = priority_req;
                    cnt_next     = '0;
                    case (kind)
                        prrs_pkg::KIND_SCHED:
                        begin
                            idx_next    = '0;
                            best_next   = '0;
                            others_next = 1'b0;
                            fsm_next    = S_BEST;
                        end
                        prrs_pkg::KIND_CREATE:
                        begin
                            idx_next = '0;
                            fsm_next = S_FREE;
                        end
                        prrs_pkg::KIND_BLOCK, prrs_pkg::KIND_EXIT:
                        begin
                            idx_next = cur_slot_reg;
                            fsm_next = S_KILL;
                        end
                        prrs_pkg::KIND_WAKE:
                        begin
                            idx_next     = prrs_pkg::IDX_W'(wake_slot);
                            wake_ok_next = (int'(wake_slot) < prrs_pkg::SLOT_COUNT);
                            fsm_next     = S_WAKE;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = 1'b0;
                            slot_next   = '0;
                        end
                    endcase
                end
            end
            S_BEST:
            begin
                if (cmp.is_ready && cmp.pri_gt)
                begin
                    best_next = rd_pri;
                end
                if (cmp.is_ready && (idx_reg != '0))
                begin
                    others_next = 1'b1;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next = '0;
                    idx_next = prrs_pkg::wrap_inc(last_pick_reg);
                    fsm_next = S_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + prrs_pkg::IDX_W'(1);
                    idx_next = prrs_pkg::wrap_inc(idx_reg);
                end
            end
            S_PICK:
            begin
                if (cmp.is_ready && cmp.pri_eq
                    && !((idx_reg == '0) && (best_reg == '0) && others_reg))
                begin
                    pick_next = idx_reg;
                    idx_next  = cur_slot_reg;
                    fsm_next  = S_DEMOTE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    pick_next = '0;
                    idx_next  = cur_slot_reg;
                    fsm_next  = S_DEMOTE;
                end
                else
                begin
                    cnt_next = cnt_reg + prrs_pkg::IDX_W'(1);
                    idx_next = prrs_pkg::wrap_inc(idx_reg);
                end
            end
            S_DEMOTE:
            begin
                if (run_flag_reg)
                begin
                    tbl_wr.st_we = 1'b1;
                    tbl_wr.st    = prrs_pkg::ST_READY;
                end
                idx_next = pick_reg;
                fsm_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                tbl_wr.st_we   = 1'b1;
                tbl_wr.st      = prrs_pkg::ST_RUNNING;
                cur_slot_next  = pick_reg;
                cur_valid_next = 1'b1;
                last_pick_next = pick_reg;
                run_flag_next  = 1'b1;
                done_next      = 1'b1;
                status_next    = 1'b0;
                slot_next      = prrs_pkg::SLOT_W'(pick_reg);
                fsm_next       = S_IDLE;
            end
            S_FREE:
            begin
                if (cmp.is_free)
                begin
                    tbl_wr.st_we  = 1'b1;
                    tbl_wr.st     = prrs_pkg::ST_READY;
                    tbl_wr.pri_we = 1'b1;
                    tbl_wr.pri    = req_pri_reg;
                    done_next     = 1'b1;
                    status_next   = 1'b0;
                    slot_next     = prrs_pkg::SLOT_W'(idx_reg);
                    fsm_next      = S_IDLE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b1;
                    slot_next   = '0;
                    fsm_next    = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + prrs_pkg::IDX_W'(1);
                    idx_next = prrs_pkg::wrap_inc(idx_reg);
                end
            end
            S_KILL:
            begin
                if (cur_valid_reg)
                begin
                    tbl_wr.st_we = 1'b1;
                    tbl_wr.st    = (op_reg == prrs_pkg::KIND_EXIT) ? prrs_pkg::ST_DEAD
                                                                   : prrs_pkg::ST_BLOCKED;
                end
                run_flag_next = 1'b0;
                done_next     = 1'b1;
                status_next   = 1'b0;
                slot_next     = '0;
                fsm_next      = S_IDLE;
            end
            S_WAKE:
            begin
                if (wake_ok_reg && cmp.is_blocked)
                begin
                    tbl_wr.st_we = 1'b1;
                    tbl_wr.st    = prrs_pkg::ST_READY;
                end
                done_next   = 1'b1;
                status_next = 1'b0;
                slot_next   = '0;
                fsm_next    = S_IDLE;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            op_reg        <= prrs_pkg::KIND_SCHED;
            last_pick_reg <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            run_flag_reg  <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            req_pri_reg   <= '0;
            best_reg      <= '0;
            others_reg    <= 1'b0;
            pick_reg      <= '0;
            wake_ok_reg   <= 1'b0;
            status_reg    <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            op_reg        <= op_next;
            last_pick_reg <= last_pick_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            run_flag_reg  <= run_flag_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            req_pri_reg   <= req_pri_next;
            best_reg      <= best_next;
            others_reg    <= others_next;
            pick_reg      <= pick_next;
            wake_ok_reg   <= wake_ok_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
        end
    end

    assign busy          = (fsm_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign running_valid = run_flag_reg;

    `PRRS_ASSERT_IMP(a_done_frees_port, done, !busy)
    `PRRS_ASSERT_NXT(a_start_goes_busy, start && !busy && (kind <= prrs_pkg::KIND_WAKE), busy)
    `PRRS_ASSERT_IMP(a_fail_slot_zero, done && status, slot == '0)
    `PRRS_ASSERT_IMP(a_sched_runs, done && (op_reg == prrs_pkg::KIND_SCHED), running_valid)
    `PRRS_ASSERT_IMP(a_run_needs_current, running_valid, cur_valid_reg)

endmodule

// ----- rtl/prrs_table.sv -----
// ----------------------------------------------------------------------------
// prrs_table
// Slot state and priority table with one indexed read and write port.
// ----------------------------------------------------------------------------
module prrs_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [prrs_pkg::IDX_W-1:0]       addr,
    input  prrs_pkg::tbl_wr_t                wr,
    output prrs_pkg::slot_st_t               rd_state,
    output logic [prrs_pkg::PRI_W-1:0]       rd_pri
);

    prrs_pkg::slot_st_t               state_reg [prrs_pkg::SLOT_COUNT];
    logic [prrs_pkg::PRI_W-1:0]       pri_reg   [prrs_pkg::SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < prrs_pkg::SLOT_COUNT; i++)
            begin
                state_reg[i] <= (i == 0) ? prrs_pkg::ST_READY : prrs_pkg::ST_FREE;
                pri_reg[i]   <= '0;
            end
        end
        else
        begin
            if (wr.st_we)
            begin
                state_reg[addr] <= wr.st;
            end
            if (wr.pri_we)
            begin
                pri_reg[addr] <= wr.pri;
            end
        end
    end

    assign rd_state = state_reg[addr];
    assign rd_pri   = pri_reg[addr];

endmodule

// ----- rtl/prrs_cmp.sv -----
// ----------------------------------------------------------------------------
// prrs_cmp
// Shared compare unit that classifies one table entry against the best priority.
// ----------------------------------------------------------------------------
module prrs_cmp (
    input  prrs_pkg::slot_st_t               entry_state,
    input  logic [prrs_pkg::PRI_W-1:0]       entry_pri,
    input  logic [prrs_pkg::PRI_W-1:0]       top_pri,
    output prrs_pkg::cmp_res_t               res
);

    always_comb
    begin
        res.is_free    = (entry_state == prrs_pkg::ST_FREE);
        res.is_ready   = (entry_state == prrs_pkg::ST_READY);
        res.is_blocked = (entry_state == prrs_pkg::ST_BLOCKED);
        res.pri_gt     = (entry_pri > top_pri);
        res.pri_eq     = (entry_pri == top_pri);
    end

endmodule

// ----- tb/sv/priority_round_robin_task_scheduler_top_tb.sv -----
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top_tb
// Drives scheduler events through the start/busy handshake and checks every
// result strobed on done against a cycle-free model of the slot table (typed
// rows against their own result). A short directed table comes first, then
// random traffic in four phases, two with sender idling, each fully drained.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_top_tb;

    import prrs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;
    localparam int DIR_N        = 25;
    localparam int PHASE_ITEMS  = 375;
    localparam int SETTLE_CYC   = 2 * SLOT_COUNT + 6;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
        logic              running_valid;
    } evt_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PRI_W-1:0]  pri;
        logic [2:0]        wslot;
        logic              typed;
        evt_result_t       res;
    } dir_row_t;

    localparam dir_row_t DIR_TBL [DIR_N] = '{
        '{KIND_BLOCK,     8'd0,   3'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_EXIT,      8'd255, 3'd7, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_WAKE,      8'd0,   3'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SPARE_LO,  8'd255, 3'd7, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SPARE_HI,  8'd170, 3'd5, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SCHED,     8'd0,   3'd0, 1'b1, '{1'b0, 3'd0, 1'b1}},
        '{KIND_BLOCK,     8'd85,  3'd2, 1'b1, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SCHED,     8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_EXIT,      8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SCHED,     8'd255, 3'd7, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd255, 3'd0, 1'b1, '{1'b0, 3'd1, 1'b1}},
        '{KIND_CREATE,    8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd128, 3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd255, 3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd1,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd255, 3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_CREATE,    8'd200, 3'd0, 1'b1, '{1'b1, 3'd0, 1'b1}},
        '{KIND_SCHED,     8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SCHED,     8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_SCHED,     8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_BLOCK,     8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_WAKE,      8'd0,   3'd6, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_WAKE,      8'd0,   3'd3, 1'b0, '{1'b0, 3'd0, 1'b0}},
        '{KIND_EXIT,      8'd0,   3'd0, 1'b0, '{1'b0, 3'd0, 1'b0}}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] kind = KIND_SCHED;
    logic [PRI_W-1:0]  priority_req = '0;
    logic [2:0]        wake_slot = '0;
    logic              done;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              running_valid;

    slot_st_t          slot_tbl [SLOT_COUNT];
    logic [PRI_W-1:0]  pri_tbl [SLOT_COUNT];
    int                last_pick;
    int                cur_slot;
    bit                cur_valid;

    evt_result_t       pending_results [$];
    int                fail_count = 0;

    priority_round_robin_task_scheduler_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .priority_req  (priority_req),
        .wake_slot     (wake_slot),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .running_valid (running_valid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic evt_result_t sched_apply_event(input logic [KIND_W-1:0] k,
                                                      input logic [PRI_W-1:0] p,
                                                      input logic [2:0] w);
        evt_result_t r;
        int          best;
        int          pick;
        int          idx;
        bit          others;
        bit          found;
        r = '0;
        case (k)
            KIND_SCHED:
            begin
                best = 0;
                others = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_tbl[i] == ST_READY && int'(pri_tbl[i]) > best)
                    begin
                        best = int'(pri_tbl[i]);
                    end
                    if (i != 0 && slot_tbl[i] == ST_READY)
                    begin
                        others = 1'b1;
                    end
                end
                pick = 0;
                found = 1'b0;
                for (int n = 0; n < SLOT_COUNT; n++)
                begin
                    idx = (last_pick + 1 + n) % SLOT_COUNT;
                    if (!found && slot_tbl[idx] == ST_READY && int'(pri_tbl[idx]) == best
                        && !(idx == 0 && best == 0 && others))
                    begin
                        pick = idx;
                        found = 1'b1;
                    end
                end
                if (cur_valid && slot_tbl[cur_slot] == ST_RUNNING)
                begin
                    slot_tbl[cur_slot] = ST_READY;
                end
                cur_slot = pick;
                cur_valid = 1'b1;
                slot_tbl[pick] = ST_RUNNING;
                last_pick = pick;
                r.slot = SLOT_W'(pick);
            end
            KIND_CREATE:
            begin
                r.status = 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (r.status && slot_tbl[i] == ST_FREE)
                    begin
                        slot_tbl[i] = ST_READY;
                        pri_tbl[i] = p;
                        r.slot = SLOT_W'(i);
                        r.status = 1'b0;
                    end
                end
            end
            KIND_BLOCK:
            begin
                if (cur_valid)
                begin
                    slot_tbl[cur_slot] = ST_BLOCKED;
                end
            end
            KIND_EXIT:
            begin
                if (cur_valid)
                begin
                    slot_tbl[cur_slot] = ST_DEAD;
                end
            end
            KIND_WAKE:
            begin
                if (int'(w) < SLOT_COUNT && slot_tbl[w] == ST_BLOCKED)
                begin
                    slot_tbl[w] = ST_READY;
                end
            end
            default:
            begin
            end
        endcase
        r.running_valid = cur_valid && slot_tbl[cur_slot] == ST_RUNNING;
        return r;
    endfunction

    task automatic issue_event(input logic [KIND_W-1:0] k, input logic [PRI_W-1:0] p,
                               input logic [2:0] w, input int idle_pct,
                               input bit typed, input evt_result_t typed_res);
        evt_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        priority_req <= p;
        wake_slot <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = sched_apply_event(k, p, w);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        evt_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d slot %0d running_valid %0d",
                       status, slot, running_valid);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    fail_count++;
                end
                if (slot !== e.slot)
                begin
                    $error("slot: expected %0d, got %0d", e.slot, slot);
                    fail_count++;
                end
                if (running_valid !== e.running_valid)
                begin
                    $error("running_valid: expected %0d, got %0d", e.running_valid,
                           running_valid);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int                idle_pcts [4];
        int                pct;
        int                roll;
        int                live;
        int                blocked [$];
        logic [KIND_W-1:0] k;
        logic [PRI_W-1:0]  p;
        logic [2:0]        w;
        idle_pcts = '{0, 59, 0, 32};
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_tbl[i] = ST_FREE;
            pri_tbl[i] = '0;
        end
        slot_tbl[0] = ST_READY;
        last_pick = 0;
        cur_slot = 0;
        cur_valid = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            issue_event(DIR_TBL[i].kind, DIR_TBL[i].pri, DIR_TBL[i].wslot, 0,
                        DIR_TBL[i].typed, DIR_TBL[i].res);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pct = ((n / 40) % 3 == 2) ? 0 : idle_pcts[ph];
                p = PRI_W'($urandom);
                w = 3'($urandom);
                live = 0;
                blocked.delete();
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_tbl[i] != ST_DEAD)
                    begin
                        live++;
                    end
                    if (slot_tbl[i] == ST_BLOCKED)
                    begin
                        blocked.push_back(i);
                    end
                end
                roll = $urandom_range(99);
                if (roll < 35)
                begin
                    k = KIND_SCHED;
                end
                else if (roll < 48)
                begin
                    k = KIND_CREATE;
                    case ($urandom_range(3))
                        0: p = '0;
                        1: p = '1;
                        2: p = PRI_W'($urandom_range(1, 3));
                        default: p = PRI_W'($urandom);
                    endcase
                end
                else if (roll < 62)
                begin
                    k = KIND_BLOCK;
                end
                else if (roll < 66)
                begin
                    k = (live > 3 || ph == 3) ? KIND_EXIT : KIND_SCHED;
                end
                else if (roll < 93)
                begin
                    k = KIND_WAKE;
                    if (blocked.size() != 0 && $urandom_range(3) != 0)
                    begin
                        w = 3'(blocked[$urandom_range(blocked.size() - 1)]);
                    end
                end
                else
                begin
                    case ($urandom_range(2))
                        0: k = KIND_SPARE_LO;
                        1: k = KIND_SPARE_MID;
                        default: k = KIND_SPARE_HI;
                    endcase
                end
                issue_event(k, p, w, pct, 1'b0, '0);
            end
            drain_results();
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end

        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("priority_round_robin_task_scheduler_top: match");
        end
        else
        begin
            $display("priority_round_robin_task_scheduler_top: mismatch");
        end
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("priority_round_robin_task_scheduler_top: mismatch");
        $finish;
    end

endmodule
